### hw/rtl/fas_pkg.sv
// Package for the fault alarm sequencer: register map, reset values,
// configuration struct and sequencer phase type.
// Depends on nothing; every other file of the block but fas_in_if uses it.
package fas_pkg;

  // Default width of the tick timers.
  localparam int TIMER_WIDTH_DEF = 20;

  // Configuration port geometry: eight registers of 32 bits.
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_IDX_W  = 3;

  // Field widths of the configuration registers.
  localparam int LEN_W    = 20;
  localparam int PERIOD_W = 8;
  localparam int REPEAT_W = 4;
  localparam int LEVEL_W  = 8;

  // Register indexes in address order.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TONE_HALF_PERIOD  = 3'd0,
    REG_TONE_PERIODS      = 3'd1,
    REG_LED_TICKS         = 3'd2,
    REG_NOTE_PAUSE_TICKS  = 3'd3,
    REG_CYCLE_PAUSE_TICKS = 3'd4,
    REG_DEBOUNCE_TICKS    = 3'd5,
    REG_REPEAT_COUNT      = 3'd6,
    REG_LED_LEVEL         = 3'd7
  } reg_idx_t;

  // Reset values of the registers.
  localparam logic [LEN_W-1:0]    RST_TONE_HALF_PERIOD  = 20'd1908;
  localparam logic [PERIOD_W-1:0] RST_TONE_PERIODS      = 8'd26;
  localparam logic [LEN_W-1:0]    RST_LED_TICKS         = 20'd100000;
  localparam logic [LEN_W-1:0]    RST_NOTE_PAUSE_TICKS  = 20'd100000;
  localparam logic [LEN_W-1:0]    RST_CYCLE_PAUSE_TICKS = 20'd300000;
  localparam logic [LEN_W-1:0]    RST_DEBOUNCE_TICKS    = 20'd50000;
  localparam logic [REPEAT_W-1:0] RST_REPEAT_COUNT      = 4'd3;
  localparam logic [LEVEL_W-1:0]  RST_LED_LEVEL         = 8'd25;

  // Current register contents, handed to the datapath as one group.
  typedef struct packed {
    logic [LEN_W-1:0]    tone_half_period;
    logic [PERIOD_W-1:0] tone_periods;
    logic [LEN_W-1:0]    led_ticks;
    logic [LEN_W-1:0]    note_pause_ticks;
    logic [LEN_W-1:0]    cycle_pause_ticks;
    logic [LEN_W-1:0]    debounce_ticks;
    logic [REPEAT_W-1:0] repeat_count;
    logic [LEVEL_W-1:0]  led_level;
  } cfg_t;

  // Sequencer phases.
  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_TONE  = 3'd1,
    PH_LED   = 3'd2,
    PH_NOTE  = 3'd3,
    PH_CYCLE = 3'd4
  } phase_t;

  // Result of one tick from the sequencer.
  typedef struct packed {
    logic               buzzer_out;
    logic [LEVEL_W-1:0] led_red;
  } seq_out_t;

endpackage

### hw/rtl/fas_in_if.sv
// Input channel of the fault alarm sequencer: one tick with the button level.
// Standalone interface; no package dependency.
interface fas_in_if;
  logic valid;
  logic ready;
  logic button_level;

  modport source (output valid, output button_level, input ready);
  modport sink   (input valid, input button_level, output ready);
endinterface

### hw/rtl/fas_out_if.sv
// Result channel of the fault alarm sequencer: buzzer, LED level, fault flag.
// Uses fas_pkg for the LED level width.
interface fas_out_if;
  logic                        valid;
  logic                        ready;
  logic                        buzzer_out;
  logic [fas_pkg::LEVEL_W-1:0] led_red;
  logic                        fault_active;

  modport source (output valid, output buzzer_out, output led_red, output fault_active,
                  input ready);
  modport sink   (input valid, input buzzer_out, input led_red, input fault_active,
                  output ready);
endinterface

### hw/rtl/fas_cfg.sv
// Configuration register file of the fault alarm sequencer, APB-style port.
// Uses fas_pkg for the register map, reset values and cfg_t.
module fas_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [fas_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [fas_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [fas_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready,
  output fas_pkg::cfg_t                    cfg
);

  fas_pkg::cfg_t    cfg_r;
  fas_pkg::reg_idx_t idx;
  logic             wr_en;

  assign pready = 1'b1;
  assign idx    = fas_pkg::reg_idx_t'(paddr[fas_pkg::CFG_ADDR_W-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign cfg    = cfg_r;

  // Register writes complete in the access phase of a transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tone_half_period  <= fas_pkg::RST_TONE_HALF_PERIOD;
      cfg_r.tone_periods      <= fas_pkg::RST_TONE_PERIODS;
      cfg_r.led_ticks         <= fas_pkg::RST_LED_TICKS;
      cfg_r.note_pause_ticks  <= fas_pkg::RST_NOTE_PAUSE_TICKS;
      cfg_r.cycle_pause_ticks <= fas_pkg::RST_CYCLE_PAUSE_TICKS;
      cfg_r.debounce_ticks    <= fas_pkg::RST_DEBOUNCE_TICKS;
      cfg_r.repeat_count      <= fas_pkg::RST_REPEAT_COUNT;
      cfg_r.led_level         <= fas_pkg::RST_LED_LEVEL;
    end else if (wr_en) begin
      unique case (idx)
        fas_pkg::REG_TONE_HALF_PERIOD:
          cfg_r.tone_half_period <= pwdata[fas_pkg::LEN_W-1:0];
        fas_pkg::REG_TONE_PERIODS:
          cfg_r.tone_periods <= pwdata[fas_pkg::PERIOD_W-1:0];
        fas_pkg::REG_LED_TICKS:
          cfg_r.led_ticks <= pwdata[fas_pkg::LEN_W-1:0];
        fas_pkg::REG_NOTE_PAUSE_TICKS:
          cfg_r.note_pause_ticks <= pwdata[fas_pkg::LEN_W-1:0];
        fas_pkg::REG_CYCLE_PAUSE_TICKS:
          cfg_r.cycle_pause_ticks <= pwdata[fas_pkg::LEN_W-1:0];
        fas_pkg::REG_DEBOUNCE_TICKS:
          cfg_r.debounce_ticks <= pwdata[fas_pkg::LEN_W-1:0];
        fas_pkg::REG_REPEAT_COUNT:
          cfg_r.repeat_count <= pwdata[fas_pkg::REPEAT_W-1:0];
        fas_pkg::REG_LED_LEVEL:
          cfg_r.led_level <= pwdata[fas_pkg::LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // Read data, zero-extended to the bus width.
  always_comb begin
    unique case (idx)
      fas_pkg::REG_TONE_HALF_PERIOD:  prdata = fas_pkg::CFG_DATA_W'(cfg_r.tone_half_period);
      fas_pkg::REG_TONE_PERIODS:      prdata = fas_pkg::CFG_DATA_W'(cfg_r.tone_periods);
      fas_pkg::REG_LED_TICKS:         prdata = fas_pkg::CFG_DATA_W'(cfg_r.led_ticks);
      fas_pkg::REG_NOTE_PAUSE_TICKS:  prdata = fas_pkg::CFG_DATA_W'(cfg_r.note_pause_ticks);
      fas_pkg::REG_CYCLE_PAUSE_TICKS: prdata = fas_pkg::CFG_DATA_W'(cfg_r.cycle_pause_ticks);
      fas_pkg::REG_DEBOUNCE_TICKS:    prdata = fas_pkg::CFG_DATA_W'(cfg_r.debounce_ticks);
      fas_pkg::REG_REPEAT_COUNT:      prdata = fas_pkg::CFG_DATA_W'(cfg_r.repeat_count);
      fas_pkg::REG_LED_LEVEL:         prdata = fas_pkg::CFG_DATA_W'(cfg_r.led_level);
      default:                        prdata = '0;
    endcase
  end

endmodule

### hw/rtl/fas_debounce.sv
// Button debouncer: toggles the fault flag after a continuous press.
// Uses fas_pkg for widths.
module fas_debounce #(
  parameter int TIMER_WIDTH = fas_pkg::TIMER_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      advance,
  input  logic                      button_level,
  input  logic [fas_pkg::LEN_W-1:0] debounce_ticks,
  output logic                      fault_nxt
);

  // Compare width covers both the timer and the configured length.
  localparam int CW = (TIMER_WIDTH > fas_pkg::LEN_W) ? TIMER_WIDTH : fas_pkg::LEN_W;
  localparam logic [CW-1:0] TMASK = CW'((64'd1 << TIMER_WIDTH) - 64'd1);

  logic                   fault_r;
  logic                   wait_release_r, wait_release_nxt;
  logic [TIMER_WIDTH-1:0] count_r, count_nxt, count_inc;
  logic [CW-1:0]          len_ext, limit;
  logic                   pressed;

  assign pressed   = ~button_level;
  assign count_inc = count_r + 1'b1;
  assign len_ext   = CW'(debounce_ticks);
  assign limit     = (len_ext > TMASK) ? TMASK : len_ext;

  // Count consecutive low ticks; after a toggle, wait for a release.
  always_comb begin
    fault_nxt        = fault_r;
    wait_release_nxt = wait_release_r;
    count_nxt        = count_r;
    if (wait_release_r) begin
      if (!pressed) begin
        wait_release_nxt = 1'b0;
        count_nxt        = '0;
      end
    end else if (pressed) begin
      count_nxt = count_inc;
      if (CW'(count_inc) >= limit) begin
        fault_nxt        = ~fault_r;
        wait_release_nxt = 1'b1;
        count_nxt        = '0;
      end
    end else begin
      count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fault_r        <= 1'b0;
      wait_release_r <= 1'b0;
      count_r        <= '0;
    end else if (advance) begin
      fault_r        <= fault_nxt;
      wait_release_r <= wait_release_nxt;
      count_r        <= count_nxt;
    end
  end

endmodule

### hw/rtl/fas_seq.sv
// Alarm sequencer: tone, LED and pause phases repeated while the fault is set.
// Uses fas_pkg for phase_t, cfg_t and seq_out_t.
module fas_seq #(
  parameter int TIMER_WIDTH = fas_pkg::TIMER_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  logic              fault,
  input  fas_pkg::cfg_t     cfg,
  output fas_pkg::seq_out_t res
);

  localparam int CW = (TIMER_WIDTH > fas_pkg::LEN_W) ? TIMER_WIDTH : fas_pkg::LEN_W;
  localparam logic [CW-1:0] TMASK = CW'((64'd1 << TIMER_WIDTH) - 64'd1);

  fas_pkg::phase_t                phase_r, phase_nxt;
  logic [TIMER_WIDTH-1:0]         timer_r, timer_nxt, timer_inc;
  logic [fas_pkg::PERIOD_W-1:0]   period_r, period_nxt, period_inc;
  logic [fas_pkg::REPEAT_W-1:0]   repeat_r, repeat_nxt, repeat_inc;
  logic                           buzz_r, buzz_nxt;
  logic [fas_pkg::LEN_W-1:0]      len_sel;
  logic [CW-1:0]                  len_ext, limit;
  logic                           done;
  logic                           tone_on;

  // One shared timer compare; the length follows the current phase.
  always_comb begin
    case (phase_r)
      fas_pkg::PH_TONE:  len_sel = cfg.tone_half_period;
      fas_pkg::PH_LED:   len_sel = cfg.led_ticks;
      fas_pkg::PH_NOTE:  len_sel = cfg.note_pause_ticks;
      default:           len_sel = cfg.cycle_pause_ticks;
    endcase
  end

  assign timer_inc  = timer_r + 1'b1;
  assign period_inc = period_r + 1'b1;
  assign repeat_inc = repeat_r + 1'b1;
  assign len_ext    = CW'(len_sel);
  assign limit      = (len_ext > TMASK) ? TMASK : len_ext;
  assign done       = (CW'(timer_inc) >= limit);
  assign tone_on    = (cfg.tone_periods != '0);

  // Next state of the phase machine and its counters.
  always_comb begin
    phase_nxt  = phase_r;
    timer_nxt  = timer_r;
    period_nxt = period_r;
    repeat_nxt = repeat_r;
    buzz_nxt   = buzz_r;
    if (!fault) begin
      phase_nxt  = fas_pkg::PH_IDLE;
      timer_nxt  = '0;
      period_nxt = '0;
      repeat_nxt = '0;
      buzz_nxt   = 1'b0;
    end else begin
      unique case (phase_r)
        fas_pkg::PH_TONE: begin
          if (!tone_on) begin
            phase_nxt = fas_pkg::PH_LED;
            timer_nxt = '0;
            buzz_nxt  = 1'b0;
          end else if (done) begin
            timer_nxt = '0;
            if (buzz_r) begin
              buzz_nxt = 1'b0;
            end else begin
              period_nxt = period_inc;
              if (period_inc >= cfg.tone_periods) begin
                phase_nxt = fas_pkg::PH_LED;
                buzz_nxt  = 1'b0;
              end else begin
                buzz_nxt = 1'b1;
              end
            end
          end else begin
            timer_nxt = timer_inc;
          end
        end
        fas_pkg::PH_LED: begin
          if (done) begin
            phase_nxt = fas_pkg::PH_NOTE;
            timer_nxt = '0;
            buzz_nxt  = 1'b0;
          end else begin
            timer_nxt = timer_inc;
          end
        end
        fas_pkg::PH_NOTE: begin
          if (done) begin
            repeat_nxt = repeat_inc;
            timer_nxt  = '0;
            if (repeat_inc >= cfg.repeat_count) begin
              phase_nxt = fas_pkg::PH_CYCLE;
              buzz_nxt  = 1'b0;
            end else begin
              phase_nxt  = fas_pkg::PH_TONE;
              period_nxt = '0;
              buzz_nxt   = tone_on;
            end
          end else begin
            timer_nxt = timer_inc;
          end
        end
        fas_pkg::PH_CYCLE: begin
          if (done) begin
            phase_nxt  = fas_pkg::PH_TONE;
            timer_nxt  = '0;
            period_nxt = '0;
            repeat_nxt = '0;
            buzz_nxt   = tone_on;
          end else begin
            timer_nxt = timer_inc;
          end
        end
        default: begin
          // Idle with the fault set: start a new cycle with the tone.
          phase_nxt  = fas_pkg::PH_TONE;
          timer_nxt  = '0;
          period_nxt = '0;
          repeat_nxt = '0;
          buzz_nxt   = tone_on;
        end
      endcase
    end
  end

  // Outputs reflect the state after this tick.
  always_comb begin
    res.buzzer_out = (phase_nxt == fas_pkg::PH_TONE) & buzz_nxt;
    res.led_red    = (phase_nxt == fas_pkg::PH_LED) ? cfg.led_level : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= fas_pkg::PH_IDLE;
      timer_r  <= '0;
      period_r <= '0;
      repeat_r <= '0;
      buzz_r   <= 1'b0;
    end else if (advance) begin
      phase_r  <= phase_nxt;
      timer_r  <= timer_nxt;
      period_r <= period_nxt;
      repeat_r <= repeat_nxt;
      buzz_r   <= buzz_nxt;
    end
  end

endmodule

### hw/rtl/fault_alarm_sequencer.sv
// Top level of the fault alarm sequencer: channels, result register, submodules.
// Depends on fas_pkg, fas_in_if, fas_out_if, fas_cfg, fas_debounce and fas_seq.
//
//   Channel  Direction  Carries
//   in_ch    sink       one tick: button_level (0 = pressed)
//   out_ch   source     buzzer_out, led_red, fault_active after that tick
//   cfg_*    slave      eight 32-bit registers at byte addresses 0x00..0x1C
//
// Debouncer and sequencer update in the cycle the tick transfers, and the
// result lands in the output register at that edge. A tick is taken whenever
// the output register is empty or its result is taken in the same cycle, so
// one tick per cycle is sustained without stalls.
// rst_n is synchronous; reset restores register defaults and an idle sequencer.
module fault_alarm_sequencer #(
  parameter int TIMER_WIDTH = fas_pkg::TIMER_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  fas_in_if.sink                         in_ch,
  fas_out_if.source                      out_ch,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [fas_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [fas_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [fas_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);

  fas_pkg::cfg_t     cfg;
  fas_pkg::seq_out_t res;
  logic              advance;
  logic              fault_nxt;
  logic              out_valid_r;
  logic              buzzer_r;
  logic [fas_pkg::LEVEL_W-1:0] led_r;
  logic              fault_r;

  // A tick transfers when the result register is free or drains this cycle.
  assign in_ch.ready = ~out_valid_r | out_ch.ready;
  assign advance     = in_ch.valid & in_ch.ready;

  fas_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  fas_debounce #(.TIMER_WIDTH(TIMER_WIDTH)) u_debounce (
    .clk            (clk),
    .rst_n          (rst_n),
    .advance        (advance),
    .button_level   (in_ch.button_level),
    .debounce_ticks (cfg.debounce_ticks),
    .fault_nxt      (fault_nxt)
  );

  fas_seq #(.TIMER_WIDTH(TIMER_WIDTH)) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .fault   (fault_nxt),
    .cfg     (cfg),
    .res     (res)
  );

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload, loaded on every input transfer.
  always_ff @(posedge clk) begin
    if (advance) begin
      buzzer_r <= res.buzzer_out;
      led_r    <= res.led_red;
      fault_r  <= fault_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.buzzer_out   = buzzer_r;
  assign out_ch.led_red      = led_r;
  assign out_ch.fault_active = fault_r;

endmodule
